### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the rtl folder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge while out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/xsr_pkg.sv
// ----------------------------------------------------------------------------
// xsr_pkg
// types and constants for the ranged xorshift32 random source
// ----------------------------------------------------------------------------
package xsr_pkg;

    localparam int unsigned WORD_W = 32;

    // xorshift triple
    localparam int unsigned XS_SHIFT_A = 13;
    localparam int unsigned XS_SHIFT_B = 17;
    localparam int unsigned XS_SHIFT_C = 5;

    localparam logic [WORD_W-1:0] XSR_RESET_WORD = 32'd1;

    typedef enum logic [1:0] {
        CMD_SEED   = 2'd0,
        CMD_NEXT32 = 2'd1,
        CMD_NEXT16 = 2'd2,
        CMD_NEXT8  = 2'd3
    } t_cmd;

    typedef enum logic {
        STATUS_OK          = 1'b0,
        STATUS_SEED_REJECT = 1'b1
    } t_status;

    typedef struct packed {
        t_cmd              command;
        logic [WORD_W-1:0] range;
        logic [WORD_W-1:0] seed_value;
        logic [WORD_W-1:0] entropy_word;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              status;
    } t_rsp;

endpackage

### rtl/xsr_core.sv
// ----------------------------------------------------------------------------
// xsr_core
// combinational datapath: xorshift advance, seeding and range scaling
// ----------------------------------------------------------------------------
module xsr_core (
    input  logic [xsr_pkg::WORD_W-1:0] i_word,
    input  xsr_pkg::t_req              i_req,
    output logic [xsr_pkg::WORD_W-1:0] o_next_word,
    output xsr_pkg::t_rsp              o_rsp
);
    import xsr_pkg::*;

    logic [WORD_W-1:0]   x1;
    logic [WORD_W-1:0]   x2;
    logic [WORD_W-1:0]   x3;
    logic [WORD_W-1:0]   mul_a;
    logic [WORD_W-1:0]   mul_b;
    logic [2*WORD_W-1:0] product;
    logic [WORD_W-1:0]   raw_value;
    logic                range_zero;
    logic                seed_zero;
    logic                entropy_zero;

    // xorshift advance
    assign x1 = i_word ^ (i_word << XS_SHIFT_A);
    assign x2 = x1 ^ (x1 >> XS_SHIFT_B);
    assign x3 = x2 ^ (x2 << XS_SHIFT_C);

    assign seed_zero    = (i_req.seed_value == '0);
    assign entropy_zero = (i_req.entropy_word == '0);

    // one shared multiplier; the byte case is moved to the top so that
    // the upper half of the product holds (w[7:0] * r[7:0]) >> 8
    always_comb begin
        mul_a      = x3;
        mul_b      = i_req.range;
        raw_value  = x3;
        range_zero = (i_req.range == '0);
        case (i_req.command)
            CMD_NEXT16: begin
                mul_b      = {16'd0, i_req.range[15:0]};
                raw_value  = {16'd0, x3[15:0]};
                range_zero = (i_req.range[15:0] == 16'd0);
            end
            CMD_NEXT8: begin
                mul_a      = {x3[7:0], 24'd0};
                mul_b      = {24'd0, i_req.range[7:0]};
                raw_value  = {24'd0, x3[7:0]};
                range_zero = (i_req.range[7:0] == 8'd0);
            end
            default: begin
            end
        endcase
    end

    assign product = (2*WORD_W)'(mul_a) * (2*WORD_W)'(mul_b);

    always_comb begin
        o_next_word  = x3;
        o_rsp.value  = range_zero ? raw_value : product[2*WORD_W-1:WORD_W];
        o_rsp.status = STATUS_OK;
        if (i_req.command == CMD_SEED) begin
            o_rsp.value = '0;
            if (!seed_zero) begin
                o_next_word = i_req.seed_value;
            end else if (!entropy_zero) begin
                o_next_word = i_req.entropy_word;
            end else begin
                o_next_word  = i_word;
                o_rsp.status = STATUS_SEED_REJECT;
            end
        end
    end

endmodule

### rtl/xorshift32_ranged_random.sv
// ----------------------------------------------------------------------------
// xorshift32_ranged_random
// ranged xorshift32 random source with a seed command
// requests come in on the req channel (valid/ready): a command, a range,
// a seed value and an entropy word; each request gives one response on the
// rsp channel (valid/ready) with a 32-bit value and a one-bit status.
// a request passes from the request register through the datapath into
// the response register, which drives the rsp channel; response valid
// rises as the request moves into the response register. throughput is
// one request per cycle while the receiver takes each response; the
// generator word is updated as a request moves into the response register,
// so the request behind it sees the new word when it moves in turn.
// reset (synchronous, active low) empties both stages and sets the word to 1.
// while the receiver stalls the response holds, the request register keeps
// one more request, and then req ready drops until the response is taken.
// a seed with seed value and entropy both zero leaves the word unchanged
// and reports status 1.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xorshift32_ranged_random (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  xsr_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output xsr_pkg::t_rsp o_rsp
);
    import xsr_pkg::*;

    // request stage
    logic              r_in_valid;
    t_req              r_req;
    // response stage
    logic              r_out_valid;
    t_rsp              r_rsp;
    // generator state
    logic [WORD_W-1:0] r_word;

    logic [WORD_W-1:0] n_word;
    t_rsp              n_rsp;
    logic              move;
    logic              req_fire;

    // request moves into the response register when the slot is free
    assign move        = r_in_valid && (!r_out_valid || i_rsp_ready);
    assign o_req_ready = !r_in_valid || move;
    assign req_fire    = i_req_valid && o_req_ready;

    xsr_core u_core (
        .i_word      (r_word),
        .i_req       (r_req),
        .o_next_word (n_word),
        .o_rsp       (n_rsp)
    );

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_word      <= XSR_RESET_WORD;
        end else begin
            if (req_fire) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_word      <= n_word;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_req <= i_req;
        end
        if (move) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

    // zero is a fixed point of xorshift and must never be reached
    `ASSERT_CLK(a_word_nonzero, i_clk, i_rst_n, r_word != '0,
        "generator word is zero")

    // a refused seed reports the error and keeps the word
    `ASSERT_NEXT(a_seed_reject, i_clk, i_rst_n,
        move && r_req.command == CMD_SEED && r_req.seed_value == '0
            && r_req.entropy_word == '0,
        o_rsp.status == STATUS_SEED_REJECT && $stable(r_word),
        "refused seed not reported or word changed")

    // next commands always report ok
    `ASSERT_NEXT(a_next_status_ok, i_clk, i_rst_n,
        move && r_req.command != CMD_SEED,
        o_rsp.status == STATUS_OK,
        "next command reported an error")

    // a stalled response must not advance the generator
    `ASSERT_NEXT(a_stall_holds_word, i_clk, i_rst_n,
        r_out_valid && !i_rsp_ready,
        $stable(r_word),
        "generator advanced while response stalled")

endmodule
